>>> rtl/rrta_pkg.sv
// Package for the ring-road traffic automaton: field widths, register map,
// request codes, reset values and the LFSR step. No dependencies.
package rrta_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;

  localparam int IDX_W  = 10;
  localparam int SPD_W  = 4;
  localparam int PROB_W = 16;
  localparam int RING_W = 11;
  localparam int SEED_W = 32;
  localparam int CELL_W = SPD_W + 1;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SLOW_PROB  = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
  localparam logic [1:0] REG_RING_LEN   = 2'd2;
  localparam logic [1:0] REG_RNG_SEED   = 2'd3;

  // Reset values
  localparam logic [PROB_W-1:0] SLOW_PROB_RST = 16'd19661;
  localparam logic [SPD_W-1:0]  MAX_SPEED_RST = 4'd5;
  localparam logic [RING_W-1:0] RING_LEN_RST  = 11'd300;
  localparam logic [SEED_W-1:0] RNG_SEED_RST  = 32'd1;

  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'hD000_0001;

  // One Galois step: shift right, fold taps in when a one drops out
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    lfsr_step = {1'b0, s[SEED_W-1:1]} ^ (s[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

>>> rtl/ring_road_traffic_automaton_top.sv
// Ring-road traffic automaton: cell memory, update sequencer, APB registers.
// Depends on rrta_pkg.
//
// Usage:
//   Request channel: drive start with in_req_type, in_cell_index,
//   in_cell_occupied and in_cell_speed; the transaction is taken at the edge
//   where start is high and busy is low. Every transaction returns exactly one
//   result, shown for one cycle with out_valid high (out_occupied, out_speed).
//   The receiver cannot stall; results must be taken when strobed.
//   Write, unknown and off-ring read requests answer in the next cycle and
//   leave busy low, so they may follow each other every cycle. A read of a
//   cell on the ring holds busy for one cycle for the memory read port and
//   answers from the registered memory read data.
//   An update walks the ring once through the single memory read port, and
//   each car found adds the steps stall, speed limit/gap, random slowdown
//   with old-cell write and new-cell write; the last step is skipped when
//   the car stops.
//   Reset: registers go to their defaults and a clearing pass writes every
//   one of the MAX_SEGMENTS cells empty, one per cycle; busy stays high for
//   the whole pass. APB writes are taken at any time, but should only be
//   issued while the block is idle.
module ring_road_traffic_automaton_top
  import rrta_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic              in_cell_occupied,
  input  logic [SPD_W-1:0]  in_cell_speed,
  output logic              out_valid,
  output logic              out_occupied,
  output logic [SPD_W-1:0]  out_speed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = AW + 1;
  localparam int LW = (CW > RING_W) ? CW : RING_W;
  localparam int GW = (CW > CELL_W) ? CW : CELL_W;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_SCAN, ST_CAR, ST_FIN, ST_MOVE, ST_DONE
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers and LFSR
  // ---------------------------------------------------------------------
  logic [PROB_W-1:0] slow_prob_r;
  logic [SPD_W-1:0]  max_speed_r;
  logic [RING_W-1:0] ring_len_r;
  logic [SEED_W-1:0] rng_seed_r;
  logic [SEED_W-1:0] lfsr_r;
  logic [SEED_W-1:0] lfsr_stepped;
  logic              lfsr_adv;
  logic              apb_wr;

  assign pready       = 1'b1;
  assign apb_wr       = psel && penable && pwrite && pready;
  assign lfsr_stepped = lfsr_step(lfsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_prob_r <= SLOW_PROB_RST;
      max_speed_r <= MAX_SPEED_RST;
      ring_len_r  <= RING_LEN_RST;
      rng_seed_r  <= RNG_SEED_RST;
      lfsr_r      <= RNG_SEED_RST;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_SLOW_PROB: slow_prob_r <= pwdata[PROB_W-1:0];
        REG_MAX_SPEED: max_speed_r <= pwdata[SPD_W-1:0];
        REG_RING_LEN:  ring_len_r  <= pwdata[RING_W-1:0];
        REG_RNG_SEED: begin
          rng_seed_r <= pwdata;
          // never let the LFSR lock at zero
          lfsr_r     <= (pwdata == '0) ? SEED_W'(1) : pwdata;
        end
        default: ;
      endcase
    end else if (lfsr_adv) begin
      lfsr_r <= lfsr_stepped;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLOW_PROB: prdata = APB_DW'(slow_prob_r);
      REG_MAX_SPEED: prdata = APB_DW'(max_speed_r);
      REG_RING_LEN:  prdata = APB_DW'(ring_len_r);
      REG_RNG_SEED:  prdata = rng_seed_r;
      default:       prdata = '0;
    endcase
  end

  // Effective ring length (clamped to 2..MAX_SEGMENTS) and speed limit
  logic [LW-1:0]    rl_ext;
  logic [CW-1:0]    ring_n;
  logic [SPD_W-1:0] vmax;

  assign rl_ext = LW'(ring_len_r);
  assign vmax   = (max_speed_r == '0) ? SPD_W'(1) : max_speed_r;

  always_comb begin
    if (rl_ext < LW'(2)) begin
      ring_n = CW'(2);
    end else if (rl_ext > LW'(MAX_SEGMENTS)) begin
      ring_n = CW'(MAX_SEGMENTS);
    end else begin
      ring_n = CW'(rl_ext);
    end
  end

  // ---------------------------------------------------------------------
  // Cell memory: bit 4 occupied, bits 3..0 speed
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0] cell_mem [MAX_SEGMENTS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= cell_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_ptr_r, clr_ptr_nxt;
  logic [CW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     chk_ptr_r, chk_ptr_nxt;
  logic              vld_r, vld_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [AW-1:0]     first_r, first_nxt;
  logic [AW-1:0]     prev_r, prev_nxt;
  logic [SPD_W-1:0]  prev_spd_r, prev_spd_nxt;
  logic [AW-1:0]     car_pos_r, car_pos_nxt;
  logic [SPD_W-1:0]  car_spd_r, car_spd_nxt;
  logic [CW-1:0]     gap_r, gap_nxt;
  logic [SPD_W-1:0]  v_r, v_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_occ_r, out_occ_nxt;
  logic [SPD_W-1:0]  out_spd_r, out_spd_nxt;

  logic              idx_in_ring;
  logic [SPD_W-1:0]  wr_spd;
  logic              car_hit;
  logic [CELL_W-1:0] spd_inc;
  logic [SPD_W-1:0]  cand;
  logic [SPD_W-1:0]  v_gap;
  logic              slow_down;
  logic [SPD_W-1:0]  v_fin;
  logic [CW-1:0]     dest_sum;
  logic [CW-1:0]     dest;

  assign idx_in_ring = XW'(in_cell_index) < XW'(ring_n);
  assign wr_spd      = (in_cell_speed > vmax) ? vmax : in_cell_speed;
  assign car_hit     = vld_r && mem_rdata_r[SPD_W];

  // speed limit then gap cut
  assign spd_inc = CELL_W'(car_spd_r) + CELL_W'(1);
  assign cand    = (spd_inc > CELL_W'(vmax)) ? vmax : spd_inc[SPD_W-1:0];
  assign v_gap   = (GW'(gap_r) < GW'(cand)) ? SPD_W'(GW'(gap_r)) : cand;

  // random slowdown: one draw per moving car
  assign slow_down = (v_r != '0) && (lfsr_stepped[SEED_W-1:SEED_W-PROB_W] < slow_prob_r);
  assign v_fin     = slow_down ? v_r - SPD_W'(1) : v_r;

  // destination around the ring; sum stays below 2n
  assign dest_sum = CW'(car_pos_r) + CW'(v_r);
  assign dest     = (dest_sum >= ring_n) ? dest_sum - ring_n : dest_sum;

  always_comb begin
    state_nxt     = state_r;
    clr_ptr_nxt   = clr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    chk_ptr_nxt   = chk_ptr_r;
    vld_nxt       = vld_r;
    have_prev_nxt = have_prev_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    prev_spd_nxt  = prev_spd_r;
    car_pos_nxt   = car_pos_r;
    car_spd_nxt   = car_spd_r;
    gap_nxt       = gap_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_occ_nxt   = 1'b0;
    out_spd_nxt   = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    lfsr_adv      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // sweep every cell empty after reset
        mem_we      = 1'b1;
        mem_waddr   = clr_ptr_r;
        clr_ptr_nxt = clr_ptr_r + AW'(1);
        if (clr_ptr_r == AW'(MAX_SEGMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_WRITE: begin
              mem_we        = idx_in_ring;
              mem_waddr     = AW'(in_cell_index);
              mem_wdata     = in_cell_occupied ? {1'b1, wr_spd} : '0;
              out_valid_nxt = 1'b1;
            end
            REQ_UPDATE: begin
              rd_ptr_nxt    = '0;
              vld_nxt       = 1'b0;
              have_prev_nxt = 1'b0;
              last_nxt      = 1'b0;
              state_nxt     = ST_SCAN;
            end
            REQ_READ: begin
              if (idx_in_ring) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_cell_index);
                state_nxt = ST_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_occ_nxt   = mem_rdata_r[SPD_W];
        out_spd_nxt   = mem_rdata_r[SPD_W] ? mem_rdata_r[SPD_W-1:0] : '0;
        state_nxt     = ST_IDLE;
      end

      ST_SCAN: begin
        if (car_hit && have_prev_r) begin
          // next car found: finish the previous one, hold the read stream
          car_pos_nxt  = prev_r;
          car_spd_nxt  = prev_spd_r;
          gap_nxt      = CW'(chk_ptr_r) - CW'(prev_r) - CW'(1);
          prev_nxt     = chk_ptr_r;
          prev_spd_nxt = mem_rdata_r[SPD_W-1:0];
          vld_nxt      = 1'b0;
          state_nxt    = ST_CAR;
        end else begin
          if (car_hit) begin
            // first car on the ring
            have_prev_nxt = 1'b1;
            first_nxt     = chk_ptr_r;
            prev_nxt      = chk_ptr_r;
            prev_spd_nxt  = mem_rdata_r[SPD_W-1:0];
          end
          if (rd_ptr_r < ring_n) begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(rd_ptr_r);
            chk_ptr_nxt = AW'(rd_ptr_r);
            rd_ptr_nxt  = rd_ptr_r + CW'(1);
            vld_nxt     = 1'b1;
          end else begin
            vld_nxt = 1'b0;
            if (!vld_r) begin
              if (have_prev_r) begin
                // last car looks ahead around the ring to the first one
                car_pos_nxt = prev_r;
                car_spd_nxt = prev_spd_r;
                gap_nxt     = ring_n - (CW'(prev_r) - CW'(first_r)) - CW'(1);
                last_nxt    = 1'b1;
                state_nxt   = ST_CAR;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          end
        end
      end

      ST_CAR: begin
        v_nxt     = v_gap;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        lfsr_adv  = (v_r != '0);
        v_nxt     = v_fin;
        mem_we    = 1'b1;
        mem_waddr = car_pos_r;
        // a stopped car stays put with speed zero; a moving one leaves
        mem_wdata = (v_fin == '0) ? {1'b1, SPD_W'(0)} : '0;
        if (v_fin != '0) begin
          state_nxt = ST_MOVE;
        end else begin
          state_nxt = last_r ? ST_DONE : ST_SCAN;
        end
      end

      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(dest);
        mem_wdata = {1'b1, v_r};
        state_nxt = last_r ? ST_DONE : ST_SCAN;
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_ptr_r   <= '0;
      rd_ptr_r    <= '0;
      vld_r       <= 1'b0;
      have_prev_r <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_occ_r   <= 1'b0;
      out_spd_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      vld_r       <= vld_nxt;
      have_prev_r <= have_prev_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      out_occ_r   <= out_occ_nxt;
      out_spd_r   <= out_spd_nxt;
    end
    chk_ptr_r  <= chk_ptr_nxt;
    first_r    <= first_nxt;
    prev_r     <= prev_nxt;
    prev_spd_r <= prev_spd_nxt;
    car_pos_r  <= car_pos_nxt;
    car_spd_r  <= car_spd_nxt;
    gap_r      <= gap_nxt;
    v_r        <= v_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_occupied = out_occ_r;
  assign out_speed    = out_spd_r;

`ifndef NO_ASSERTIONS
  // a write transaction answers in the next cycle
  a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_WRITE) |=> out_valid)
    else $error("write transaction without result strobe");

  // an empty cell never reports a speed
  a_empty_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_occupied) |-> (out_speed == '0))
    else $error("empty result with nonzero speed");

  // no result strobe while the clearing pass runs
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result strobe during clearing pass");

  // stored cars never exceed the speed limit
  a_store_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_wdata[SPD_W]) |-> (mem_wdata[SPD_W-1:0] <= vmax))
    else $error("car stored above speed limit");
`endif

endmodule
